@@ sv/asc_pkg.sv @@
// ----------------------------------------------------------------------------
// asc_pkg
// Shared constants, codes and types of the Akima spline coefficient block.
// ----------------------------------------------------------------------------
package asc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_POINTS = 65536;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int TIME_W = 32;
  localparam int LVL_W  = 32;
  localparam int DY_W   = 33;
  localparam int COEF_W = 48;
  localparam int IDX_W  = 16;
  localparam int STAT_W = 2;

  localparam int NUM_W     = COEF_W + 4;
  localparam int DEN_W     = COEF_W + 1;
  localparam int WT_W      = FRAC_BITS + 1;
  localparam int DIV_STEPS = NUM_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [COEF_W-1:0] SAT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] SAT_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_ZERO_DX = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    SRC_SLOPE = 3'd0,
    SRC_M     = 3'd1,
    SRC_P2    = 3'd2,
    SRC_P3A   = 3'd3,
    SRC_P3B   = 3'd4,
    SRC_WT    = 3'd5
  } div_src_t;

  typedef struct packed {
    logic       in_ready;
    logic       div_start;
    div_src_t   div_src;
    logic       shift;
    logic       extrap1;
    logic       extrap2;
    logic       flush_push;
    logic       tan_mean;
    logic       tan_mul;
    logic       tan_fin;
    logic       ct_load;
    logic       out_load;
    logic       out_short;
    logic [1:0] slot;
    logic       last;
    logic       advance;
    logic       clear;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic out_busy;
    logic tan_zero;
    logic fin;
    logic k_ge1;
    logic k_eq2;
    logic k_ge3;
    logic k_lt3;
  } dp_stat_t;

  // saturate a value two bits wider than a coefficient
  function automatic logic [COEF_W-1:0] sat_coef(input logic [COEF_W+1:0] v);
    logic [COEF_W-1:0] r;
    if ((v[COEF_W+1:COEF_W-1] == 3'b000) || (v[COEF_W+1:COEF_W-1] == 3'b111)) begin
      r = v[COEF_W-1:0];
    end else if (v[COEF_W+1]) begin
      r = SAT_MIN;
    end else begin
      r = SAT_MAX;
    end
    return r;
  endfunction

endpackage

@@ sv/asc_if.sv @@
// ----------------------------------------------------------------------------
// asc_in_if / asc_out_if
// Valid/ready channels for input points and coefficient results.
// ----------------------------------------------------------------------------
interface asc_in_if;
  import asc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [TIME_W-1:0]        sample_time;
  logic signed [LVL_W-1:0]  sample_level;
  logic                     final_point;
  modport source (output valid, sample_time, sample_level, final_point, input ready);
  modport sink (input valid, sample_time, sample_level, final_point, output ready);
endinterface

interface asc_out_if;
  import asc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         interval_index;
  logic signed [LVL_W-1:0]  start_level;
  logic signed [COEF_W-1:0] coef_linear;
  logic signed [COEF_W-1:0] coef_quadratic;
  logic signed [COEF_W-1:0] coef_cubic;
  logic [STAT_W-1:0]        status;
  logic                     last_result;
  modport source (output valid, interval_index, start_level, coef_linear, coef_quadratic,
                  coef_cubic, status, last_result, input ready);
  modport sink (input valid, interval_index, start_level, coef_linear, coef_quadratic,
                coef_cubic, status, last_result, output ready);
endinterface

@@ sv/akima_spline_coefficients.sv @@
// ----------------------------------------------------------------------------
// akima_spline_coefficients
// Streaming Akima spline coefficient generator, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// One point is taken at a time; in_ch.ready is high only while the sequencer
// is idle. All quotients go through one restoring divider that makes one
// quotient bit per cycle over 68 bits. A point that closes an interval takes
// about six divisions (slope, tangent weight, slope again, quadratic, and two
// for the cubic), and a final point flushes three intervals. A finished result
// sits in the output register while work on the next interval goes on; the
// sequencer waits only when it must load a new result into a register that
// has not been taken yet.
module akima_spline_coefficients (
  input  logic      clk,
  input  logic      rst_n,
  asc_in_if.sink    in_ch,
  asc_out_if.source out_ch
);
  import asc_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  asc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  asc_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .stat   (stat)
  );

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !stat.out_busy)
    else $error("result register overwritten");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_ch.valid)
    else $error("loaded result not presented");

  a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !stat.div_busy)
    else $error("point taken during division");

endmodule

@@ sv/asc_div.sv @@
// ----------------------------------------------------------------------------
// asc_div
// Shared restoring divider: saturated signed fixed point quotient
// num*2^F/den, worked on |num| with the sign of num, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asc_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             tan_mode,
  input  logic signed [asc_pkg::NUM_W-1:0] num,
  input  logic [asc_pkg::DEN_W-1:0]        den,
  output logic                             busy,
  output logic                             done,
  output logic signed [asc_pkg::COEF_W-1:0] res
);
  import asc_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DIV_STEPS-1:0] dvd_r, dvd_nxt;
  logic [COEF_W:0]      q_r, q_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 neg_r, neg_nxt;
  logic [COEF_W-1:0]    lim_r, lim_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [COEF_W-1:0]    res_r, res_nxt;

  logic [NUM_W-1:0]  mag;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_sub;
  logic              ge;
  logic [COEF_W:0]   q_step;
  logic              ovf_step;
  logic [COEF_W-1:0] q_clamp;

  always_comb begin
    mag      = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    rem_sh   = {rem_r, dvd_r[DIV_STEPS-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    ge       = (rem_sh >= {1'b0, den_r});
    q_step   = {q_r[COEF_W-1:0], ge};
    ovf_step = ovf_r | q_r[COEF_W];
    q_clamp  = (ovf_step || (q_step > {1'b0, lim_r})) ? lim_r : q_step[COEF_W-1:0];

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    ovf_nxt  = ovf_r;
    neg_nxt  = neg_r;
    lim_nxt  = lim_r;
    den_nxt  = den_r;
    res_nxt  = res_r;

    if (start && !busy_r) begin
      neg_nxt = num[NUM_W-1];
      den_nxt = den;
      rem_nxt = '0;
      q_nxt   = '0;
      ovf_nxt = 1'b0;
      dvd_nxt = {mag, {FRAC_BITS{1'b0}}};
      cnt_nxt = DIV_CNT_W'(DIV_STEPS);
      if (tan_mode) begin
        lim_nxt = COEF_W'(1) << FRAC_BITS;
      end else if (num[NUM_W-1]) begin
        lim_nxt = SAT_MIN;
      end else begin
        lim_nxt = SAT_MAX;
      end
      if (mag == '0) begin
        res_nxt  = '0;
        done_nxt = 1'b1;
      end else if (den == '0) begin
        res_nxt  = num[NUM_W-1] ? SAT_MIN : SAT_MAX;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      dvd_nxt = {dvd_r[DIV_STEPS-2:0], 1'b0};
      q_nxt   = q_step;
      ovf_nxt = ovf_step;
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = neg_r ? COEF_W'(-q_clamp) : q_clamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    q_r   <= q_nxt;
    ovf_r <= ovf_nxt;
    neg_r <= neg_nxt;
    lim_r <= lim_nxt;
    den_r <= den_nxt;
    res_r <= res_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign res  = res_r;

endmodule

@@ sv/asc_datapath.sv @@
// ----------------------------------------------------------------------------
// asc_datapath
// Point history, slope window, tangent unit, coefficient registers and the
// result register, driven by controller commands.
// ----------------------------------------------------------------------------
module asc_datapath (
  input  logic               clk,
  input  logic               rst_n,
  asc_in_if.sink             in_ch,
  asc_out_if.source          out_ch,
  input  asc_pkg::cmd_t      cmd,
  output asc_pkg::dp_stat_t  stat
);
  import asc_pkg::*;

  logic [TIME_W-1:0]        in_time_r;
  logic signed [LVL_W-1:0]  in_level_r;
  logic                     fin_r;
  logic [TIME_W-1:0]        prev_time_r;
  logic signed [LVL_W-1:0]  prev_level_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [TIME_W-1:0]        pdx_r [3];
  logic signed [DY_W-1:0]   pdy_r [3];
  logic signed [LVL_W-1:0]  psl_r [3];
  logic signed [COEF_W-1:0] win_r [4];
  logic signed [COEF_W-1:0] ct_r, t1_r, m_r, p2_r, p3a_r, p3_r;
  logic [WT_W-1:0]          wt_r;
  logic [COEF_W:0]          prod_hi_r;
  logic [FRAC_BITS+WT_W-1:0] prod_lo_r;
  logic                     dneg_r;

  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_idx_r;
  logic signed [LVL_W-1:0]  out_sl_r;
  logic signed [COEF_W-1:0] out_p1_r, out_p2_r, out_p3_r;
  logic [STAT_W-1:0]        out_st_r;
  logic                     out_last_r;

  logic                     div_busy, div_done;
  logic signed [COEF_W-1:0] div_res;
  logic signed [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]         div_den;

  logic [COEF_W:0]     da, db, dd, msum;
  logic [COEF_W:0]     msum_rnd;
  logic [COEF_W-1:0]   abs_a, abs_b, dmag;
  logic [DEN_W-1:0]    sum_ab;
  logic [COEF_W-1:0]   mean;
  logic [COEF_W:0]     part;
  logic [COEF_W-1:0]   t1_fin;
  logic [COEF_W-1:0]   ext1, ext2, ext3;
  logic                in_acc;
  logic [CNT_W-1:0]    idx_full;

  function automatic logic [COEF_W+1:0] twice_minus(input logic [COEF_W-1:0] x,
                                                    input logic [COEF_W-1:0] y);
    logic [COEF_W+1:0] xs, ys;
    xs = {{2{x[COEF_W-1]}}, x};
    ys = {{2{y[COEF_W-1]}}, y};
    return (xs << 1) - ys;
  endfunction

  function automatic logic signed [NUM_W-1:0] sx(input logic [COEF_W-1:0] x);
    return NUM_W'(signed'(x));
  endfunction

  always_comb begin
    in_acc = in_ch.valid && cmd.in_ready;

    da     = {win_r[3][COEF_W-1], win_r[3]} - {win_r[2][COEF_W-1], win_r[2]};
    db     = {win_r[1][COEF_W-1], win_r[1]} - {win_r[0][COEF_W-1], win_r[0]};
    abs_a  = da[COEF_W] ? COEF_W'(-da) : da[COEF_W-1:0];
    abs_b  = db[COEF_W] ? COEF_W'(-db) : db[COEF_W-1:0];
    sum_ab = {1'b0, abs_a} + {1'b0, abs_b};

    // mean truncated toward zero
    msum     = {win_r[1][COEF_W-1], win_r[1]} + {win_r[2][COEF_W-1], win_r[2]};
    msum_rnd = msum + {{COEF_W{1'b0}}, msum[COEF_W]};
    mean     = msum_rnd[COEF_W:1];

    dd   = {win_r[2][COEF_W-1], win_r[2]} - {win_r[1][COEF_W-1], win_r[1]};
    dmag = dd[COEF_W] ? COEF_W'(-dd) : dd[COEF_W-1:0];

    part   = prod_hi_r + (COEF_W+1)'(prod_lo_r >> FRAC_BITS);
    t1_fin = dneg_r ? (win_r[1] - part[COEF_W-1:0]) : (win_r[1] + part[COEF_W-1:0]);

    ext1 = sat_coef(twice_minus(win_r[2], win_r[3]));
    ext2 = sat_coef(twice_minus(win_r[1], win_r[2]));
    ext3 = sat_coef(twice_minus(win_r[3], win_r[2]));

    div_den = {{(DEN_W-TIME_W){1'b0}}, pdx_r[cmd.slot]};
    case (cmd.div_src)
      SRC_SLOPE: begin
        div_num = NUM_W'(pdy_r[2]);
        div_den = {{(DEN_W-TIME_W){1'b0}}, pdx_r[2]};
      end
      SRC_M:   div_num = NUM_W'(pdy_r[cmd.slot]);
      SRC_P2:  div_num = sx(m_r) + (sx(m_r) <<< 1) - (sx(ct_r) <<< 1) - sx(t1_r);
      SRC_P3A: div_num = sx(ct_r) + sx(t1_r) - (sx(m_r) <<< 1);
      SRC_P3B: div_num = sx(p3a_r);
      SRC_WT: begin
        div_num = {{(NUM_W-COEF_W){1'b0}}, abs_b};
        div_den = sum_ab;
      end
      default: div_num = '0;
    endcase

    idx_full = cnt_r - CNT_W'(3) + CNT_W'(cmd.slot);

    stat.div_busy = div_busy;
    stat.div_done = div_done;
    stat.out_busy = out_valid_r && !out_ch.ready;
    stat.tan_zero = (sum_ab == '0);
    stat.fin      = fin_r || (cnt_r >= CNT_W'(MAX_POINTS - 1));
    stat.k_ge1    = (cnt_r >= CNT_W'(1));
    stat.k_eq2    = (cnt_r == CNT_W'(2));
    stat.k_ge3    = (cnt_r >= CNT_W'(3));
    stat.k_lt3    = (cnt_r < CNT_W'(3));
  end

  asc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .tan_mode (cmd.div_src == SRC_WT),
    .num      (div_num),
    .den      (div_den),
    .busy     (div_busy),
    .done     (div_done),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      prev_time_r  <= '0;
      prev_level_r <= '0;
      cnt_r        <= '0;
      ct_r         <= '0;
      for (int i = 0; i < 3; i++) begin
        pdx_r[i] <= '0;
        pdy_r[i] <= '0;
        psl_r[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (cmd.shift) begin
        pdx_r[0] <= pdx_r[1];
        pdx_r[1] <= pdx_r[2];
        pdx_r[2] <= in_time_r - prev_time_r;
        pdy_r[0] <= pdy_r[1];
        pdy_r[1] <= pdy_r[2];
        pdy_r[2] <= DY_W'(in_level_r) - DY_W'(prev_level_r);
        psl_r[0] <= psl_r[1];
        psl_r[1] <= psl_r[2];
        psl_r[2] <= prev_level_r;
      end
      if (div_done && (cmd.div_src == SRC_SLOPE)) begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= win_r[3];
        win_r[3] <= div_res;
      end
      if (cmd.extrap1) begin
        win_r[1] <= ext1;
      end
      if (cmd.extrap2) begin
        win_r[0] <= ext2;
      end
      if (cmd.flush_push) begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= win_r[3];
        win_r[3] <= ext3;
      end
      if (cmd.ct_load) begin
        ct_r <= t1_r;
      end
      if (cmd.advance) begin
        prev_time_r  <= in_time_r;
        prev_level_r <= in_level_r;
        cnt_r        <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_time_r  <= in_ch.sample_time;
      in_level_r <= in_ch.sample_level;
      fin_r      <= in_ch.final_point;
    end
    if (div_done) begin
      case (cmd.div_src)
        SRC_M:   m_r   <= div_res;
        SRC_P2:  p2_r  <= div_res;
        SRC_P3A: p3a_r <= div_res;
        SRC_P3B: p3_r  <= div_res;
        SRC_WT:  wt_r  <= div_res[WT_W-1:0];
        default: ;
      endcase
    end
    if (cmd.tan_mean) begin
      t1_r <= mean;
    end
    if (cmd.tan_mul) begin
      prod_hi_r <= (COEF_W+1)'(dmag[COEF_W-1:FRAC_BITS] * wt_r);
      prod_lo_r <= dmag[FRAC_BITS-1:0] * wt_r;
      dneg_r    <= dd[COEF_W];
    end
    if (cmd.tan_fin) begin
      t1_r <= t1_fin;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      if (cmd.out_short) begin
        out_idx_r  <= '0;
        out_sl_r   <= '0;
        out_p1_r   <= '0;
        out_p2_r   <= '0;
        out_p3_r   <= '0;
        out_st_r   <= ST_SHORT;
        out_last_r <= 1'b1;
      end else begin
        out_idx_r  <= idx_full[IDX_W-1:0];
        out_sl_r   <= psl_r[cmd.slot];
        out_p1_r   <= ct_r;
        out_p2_r   <= p2_r;
        out_p3_r   <= p3_r;
        out_st_r   <= (pdx_r[cmd.slot] == '0) ? ST_ZERO_DX : ST_OK;
        out_last_r <= cmd.last;
      end
    end
  end

  assign in_ch.ready           = cmd.in_ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.interval_index = out_idx_r;
  assign out_ch.start_level    = out_sl_r;
  assign out_ch.coef_linear    = out_p1_r;
  assign out_ch.coef_quadratic = out_p2_r;
  assign out_ch.coef_cubic     = out_p3_r;
  assign out_ch.status         = out_st_r;
  assign out_ch.last_result    = out_last_r;

endmodule

@@ sv/asc_ctrl.sv @@
// ----------------------------------------------------------------------------
// asc_ctrl
// Sequencer: steps each point through slope, tangent and coefficient work
// on the shared divider and issues result loads.
// ----------------------------------------------------------------------------
module asc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  asc_pkg::dp_stat_t  stat,
  output asc_pkg::cmd_t      cmd
);
  import asc_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_DECIDE  = 18'h00002,
    S_SHORT   = 18'h00004,
    S_SHIFT   = 18'h00008,
    S_SLOPE   = 18'h00010,
    S_EXT1    = 18'h00020,
    S_EXT2    = 18'h00040,
    S_TAN     = 18'h00080,
    S_TAN_MUL = 18'h00100,
    S_TAN_FIN = 18'h00200,
    S_TAN_END = 18'h00400,
    S_EM_M    = 18'h00800,
    S_EM_P2   = 18'h01000,
    S_EM_P3A  = 18'h02000,
    S_EM_P3B  = 18'h04000,
    S_EM_LOAD = 18'h08000,
    S_FLUSH   = 18'h10000,
    S_DONE    = 18'h20000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] slot_r, slot_nxt;
  logic       div_go;

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    cmd       = '0;
    cmd.slot  = slot_r;
    cmd.div_src = SRC_SLOPE;
    div_go    = !stat.div_busy && !stat.div_done;
    case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        slot_nxt = 2'd0;
        if (stat.fin && stat.k_lt3) begin
          state_nxt = S_SHORT;
        end else if (stat.k_ge1) begin
          state_nxt = S_SHIFT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHORT: begin
        if (!stat.out_busy) begin
          cmd.out_load  = 1'b1;
          cmd.out_short = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        state_nxt = S_SLOPE;
      end
      S_SLOPE: begin
        cmd.div_src   = SRC_SLOPE;
        cmd.div_start = div_go;
        if (stat.div_done) begin
          if (stat.k_eq2) begin
            state_nxt = S_EXT1;
          end else if (stat.k_ge3) begin
            state_nxt = S_TAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_EXT1: begin
        cmd.extrap1 = 1'b1;
        state_nxt   = S_EXT2;
      end
      S_EXT2: begin
        cmd.extrap2 = 1'b1;
        state_nxt   = S_TAN;
      end
      S_TAN: begin
        cmd.div_src = SRC_WT;
        if (stat.tan_zero) begin
          cmd.tan_mean = 1'b1;
          state_nxt    = S_TAN_END;
        end else begin
          cmd.div_start = div_go;
          if (stat.div_done) begin
            state_nxt = S_TAN_MUL;
          end
        end
      end
      S_TAN_MUL: begin
        cmd.tan_mul = 1'b1;
        state_nxt   = S_TAN_FIN;
      end
      S_TAN_FIN: begin
        cmd.tan_fin = 1'b1;
        state_nxt   = S_TAN_END;
      end
      S_TAN_END: begin
        if (stat.k_eq2) begin
          cmd.ct_load = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_EM_M;
        end
      end
      S_EM_M: begin
        cmd.div_src   = SRC_M;
        cmd.div_start = div_go;
        if (stat.div_done) begin
          state_nxt = S_EM_P2;
        end
      end
      S_EM_P2: begin
        cmd.div_src   = SRC_P2;
        cmd.div_start = div_go;
        if (stat.div_done) begin
          state_nxt = S_EM_P3A;
        end
      end
      S_EM_P3A: begin
        cmd.div_src   = SRC_P3A;
        cmd.div_start = div_go;
        if (stat.div_done) begin
          state_nxt = S_EM_P3B;
        end
      end
      S_EM_P3B: begin
        cmd.div_src   = SRC_P3B;
        cmd.div_start = div_go;
        if (stat.div_done) begin
          state_nxt = S_EM_LOAD;
        end
      end
      S_EM_LOAD: begin
        cmd.last = stat.fin && (slot_r == 2'd2);
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.ct_load  = 1'b1;
          if (stat.fin && (slot_r != 2'd2)) begin
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_FLUSH: begin
        cmd.flush_push = 1'b1;
        slot_nxt       = slot_r + 2'd1;
        state_nxt      = S_TAN;
      end
      S_DONE: begin
        if (stat.fin) begin
          cmd.clear = 1'b1;
        end else begin
          cmd.advance = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
    end
  end

endmodule

@@ test/akima_spline_coefficients_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akima_spline_coefficients_tb
// Streams point sets through the coefficient block under varying idle and
// stall patterns, predicts every coefficient result in a scoreboard and
// compares them field by field.
// ----------------------------------------------------------------------------
module akima_spline_coefficients_tb;
  import asc_pkg::*;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [LVL_W-1:0]  y0;
    logic [COEF_W-1:0] p1;
    logic [COEF_W-1:0] p2;
    logic [COEF_W-1:0] p3;
    logic [STAT_W-1:0] st;
    logic              last;
  } coef_res_t;

  class spline_scoreboard;
    longint          slopes[4];
    bit [31:0]       prev_t;
    longint          prev_l;
    bit [31:0]       pend_dx[3];
    longint          pend_dy[3];
    longint          pend_y0[3];
    longint          cur_tan;
    int unsigned     npts;
    coef_res_t       pending[$];
    int              errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      for (int i = 0; i < 4; i++) slopes[i] = 0;
      for (int i = 0; i < 3; i++) begin
        pend_dx[i] = 0; pend_dy[i] = 0; pend_y0[i] = 0;
      end
      prev_t = 0; prev_l = 0; cur_tan = 0; npts = 0;
    endfunction

    function longint sat48(longint v);
      longint hi, lo;
      hi = 64'sh7FFF_FFFF_FFFF;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function longint unsigned frac_div(longint unsigned a, longint unsigned d,
                                       longint unsigned lim);
      longint unsigned q, r;
      q = a / d;
      r = a % d;
      if (q > (lim >> FRAC_BITS)) return lim;
      q = q << FRAC_BITS;
      for (int b = FRAC_BITS - 1; b >= 0; b--) begin
        r = r << 1;
        if (r >= d) begin
          r = r - d;
          q = q | (64'd1 << b);
        end
      end
      return (q > lim) ? lim : q;
    endfunction

    function longint qdiv(longint num, bit [31:0] den);
      bit neg;
      longint unsigned mag, lim, q;
      longint hi;
      hi = 64'sh7FFF_FFFF_FFFF;
      neg = num < 0;
      mag = neg ? -num : num;
      lim = neg ? longint'(hi) + 1 : longint'(hi);
      if (mag == 0) return 0;
      if (den == 0) return neg ? -hi - 1 : hi;
      q = frac_div(mag, {32'd0, den}, lim);
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function longint tangent_at();
      longint unsigned a, b, wt, mag, part;
      longint d;
      a = (slopes[3] >= slopes[2]) ? slopes[3] - slopes[2] : slopes[2] - slopes[3];
      b = (slopes[1] >= slopes[0]) ? slopes[1] - slopes[0] : slopes[0] - slopes[1];
      if (a + b == 0) return (slopes[1] + slopes[2]) / 2;
      wt = frac_div(b, a + b, 64'd1 << FRAC_BITS);
      d = slopes[2] - slopes[1];
      mag = (d < 0) ? -d : d;
      part = (mag >> FRAC_BITS) * wt + (((mag & ((64'd1 << FRAC_BITS) - 1)) * wt)
             >> FRAC_BITS);
      return (d < 0) ? slopes[1] - longint'(part) : slopes[1] + longint'(part);
    endfunction

    function void shift_slope(longint m);
      slopes[0] = slopes[1]; slopes[1] = slopes[2]; slopes[2] = slopes[3];
      slopes[3] = m;
    endfunction

    function void add_interval(int pi, int unsigned idx, longint t0, longint t1,
                               bit last);
      coef_res_t r;
      longint m;
      m = qdiv(pend_dy[pi], pend_dx[pi]);
      r.idx  = idx[IDX_W-1:0];
      r.y0   = pend_y0[pi][LVL_W-1:0];
      r.p1   = t0[COEF_W-1:0];
      r.p2   = COEF_W'(qdiv(3 * m - 2 * t0 - t1, pend_dx[pi]));
      r.p3   = COEF_W'(qdiv(qdiv(t0 + t1 - 2 * m, pend_dx[pi]), pend_dx[pi]));
      r.st   = (pend_dx[pi] == 0) ? ST_ZERO_DX : ST_OK;
      r.last = last;
      pending = {pending, r};
    endfunction

    function void note_point(bit [31:0] t, bit [31:0] lvl_raw, bit fin);
      coef_res_t r;
      longint lvl, t1;
      int unsigned k;
      lvl = longint'($signed(lvl_raw));
      k = npts;
      if (k >= MAX_POINTS - 1) fin = 1;
      if (fin && k < 3) begin
        r = '{0, 0, 0, 0, 0, ST_SHORT, 1'b1};
        pending = {pending, r};
        clear();
        return;
      end
      if (k >= 1) begin
        for (int i = 0; i < 2; i++) begin
          pend_dx[i] = pend_dx[i+1]; pend_dy[i] = pend_dy[i+1];
          pend_y0[i] = pend_y0[i+1];
        end
        pend_dx[2] = t - prev_t;
        pend_dy[2] = lvl - prev_l;
        pend_y0[2] = prev_l;
        shift_slope(qdiv(lvl - prev_l, t - prev_t));
      end
      if (k == 2) begin
        slopes[1] = sat48(2 * slopes[2] - slopes[3]);
        slopes[0] = sat48(2 * slopes[1] - slopes[2]);
        cur_tan = tangent_at();
      end
      if (k >= 3) begin
        t1 = tangent_at();
        add_interval(0, k - 3, cur_tan, t1, 1'b0);
        cur_tan = t1;
      end
      if (fin) begin
        for (int i = 1; i <= 2; i++) begin
          shift_slope(sat48(2 * slopes[3] - slopes[2]));
          t1 = tangent_at();
          add_interval(i, k - 3 + i, cur_tan, t1, i == 2);
          cur_tan = t1;
        end
        clear();
      end else begin
        prev_t = t; prev_l = lvl; npts = k + 1;
      end
    endfunction

    function void check_result(coef_res_t a);
      coef_res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result idx=%0d", a.idx);
        return;
      end
      e = pending[0];
      pending.delete(0);
      if (a.idx != e.idx || a.y0 != e.y0 || a.p1 != e.p1 || a.p2 != e.p2 ||
          a.p3 != e.p3 || a.st != e.st || a.last != e.last) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch exp idx=%0d y0=%h p1=%h p2=%h p3=%h st=%0d last=%0d",
                   e.idx, e.y0, e.p1, e.p2, e.p3, e.st, e.last);
          $display("         act idx=%0d y0=%h p1=%h p2=%h p3=%h st=%0d last=%0d",
                   a.idx, a.y0, a.p1, a.p2, a.p3, a.st, a.last);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n;
  asc_in_if  in_ch();
  asc_out_if out_ch();

  akima_spline_coefficients uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #5 clk = ~clk;

  spline_scoreboard sb = new();
  int idle_mode = 0;
  int sent = 0;
  bit [31:0] cur_t;
  bit [31:0] cur_l;

  initial begin
    #50ms;
    $display("akima_spline_coefficients verification failed");
    $finish;
  end

  always @(posedge clk) begin
    coef_res_t a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a.idx = out_ch.interval_index; a.y0 = out_ch.start_level;
      a.p1 = out_ch.coef_linear; a.p2 = out_ch.coef_quadratic;
      a.p3 = out_ch.coef_cubic; a.st = out_ch.status; a.last = out_ch.last_result;
      sb.check_result(a);
    end
  end

  // receiver with one long hold-off
  initial begin
    int cyc;
    cyc = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 20000 && cyc < 26000) out_ch.ready <= 1'b0;
      else if (idle_mode == 2) out_ch.ready <= $urandom_range(99) >= 72;
      else if (idle_mode == 3) out_ch.ready <= $urandom_range(99) >= 13;
      else out_ch.ready <= 1'b1;
    end
  end

  task automatic send_point(bit [31:0] t, bit [31:0] lvl, bit fin);
    int pct;
    pct = (idle_mode == 1) ? 72 : (idle_mode == 3) ? 13 : 0;
    if ($urandom_range(99) < pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < pct) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_time <= t;
    in_ch.sample_level <= lvl;
    in_ch.final_point <= fin;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_point(t, lvl, fin);
    sent++;
  endtask

  task automatic send_set(int n, bit zero_ok);
    bit [31:0] dx;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: dx = zero_ok ? 0 : 1;
        1: dx = $urandom;
        2: dx = 1;
        default: dx = $urandom_range(1, 1 << $urandom_range(4, 20));
      endcase
      cur_t = cur_t + dx;
      case ($urandom_range(9))
        0: cur_l = $urandom;
        1: cur_l = 32'h7FFF_FFFF;
        2: cur_l = 32'h8000_0000;
        3: cur_l = cur_l;
        default: cur_l = cur_l + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      endcase
      send_point(cur_t, cur_l, i == n - 1);
    end
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.sample_time <= '0;
    in_ch.sample_level <= '0;
    in_ch.final_point <= 1'b0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // short sets
    send_point(32'd0, 32'h0001_0000, 1'b1);
    send_point(32'd5, 32'h0, 1'b0); send_point(32'd9, 32'h1, 1'b1);
    send_point(32'd1, 32'h7FFF_FFFF, 1'b0); send_point(32'd2, 32'h8000_0000, 1'b0);
    send_point(32'd3, 32'h0, 1'b1);
    // extremes in time and level
    send_point(32'd0, 32'h8000_0000, 1'b0);
    send_point(32'd1, 32'h7FFF_FFFF, 1'b0);
    send_point(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
    send_point(32'hFFFF_FFFE, 32'h7FFF_FFFF, 1'b1);
    // flat levels, both weights zero
    for (int i = 0; i < 5; i++) send_point(i * 32'h1_0000, 32'h0003_0000, i == 4);
    // zero time step
    send_point(32'd100, 32'h0, 1'b0); send_point(32'd200, 32'h10000, 1'b0);
    send_point(32'd200, 32'h20000, 1'b0); send_point(32'd200, 32'h20000, 1'b0);
    send_point(32'd300, 32'hFFFF0000, 1'b1);
    cur_t = $urandom;
    cur_l = $urandom;
    while (sent < 380) begin
      idle_mode = (sent / 95) % 4;
      if ($urandom_range(7) == 0) send_set($urandom_range(1, 3), 1'b1);
      else send_set($urandom_range(4, 10), $urandom_range(3) == 0);
    end
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("akima_spline_coefficients verification clean");
    else
      $display("akima_spline_coefficients verification failed");
    $finish;
  end
endmodule

@@ sim.f @@
sv/asc_pkg.sv
sv/asc_if.sv
sv/asc_div.sv
sv/asc_datapath.sv
sv/asc_ctrl.sv
sv/akima_spline_coefficients.sv
test/akima_spline_coefficients_tb.sv
